>>> rtl/npd_pkg.sv
// ----------------------------------------------------------------------------
// npd_pkg
// Shared types and constants of the noise-shaped PCM dither unit.
// ----------------------------------------------------------------------------
package npd_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int FRAC_BITS_DEF = 28;

    localparam int unsigned PEAK_W = 28;

    localparam logic [31:0]       LCG_MUL  = 32'h0019_660D;
    localparam logic [31:0]       LCG_INC  = 32'h3C6E_F35F;
    localparam logic [31:0]       SAT_U32  = 32'hFFFF_FFFF;
    localparam logic [7:0]        SIGN_FLIP = 8'h80;
    localparam logic [PEAK_W-1:0] PEAK_SAT = 28'hFFF_FFFF;

    // Output sample formats.
    localparam logic [2:0] FMT_S8    = 3'd0;
    localparam logic [2:0] FMT_U8    = 3'd1;
    localparam logic [2:0] FMT_S16LE = 3'd2;
    localparam logic [2:0] FMT_S16BE = 3'd3;
    localparam logic [2:0] FMT_S24LE = 3'd4;
    localparam logic [2:0] FMT_S24BE = 3'd5;
    localparam logic [2:0] FMT_S32LE = 3'd6;
    localparam logic [2:0] FMT_S32BE = 3'd7;

    // Per-channel state held in the state memory. The generator keeps both
    // its current value and the value after it, so the multiply for the
    // next step is off the dither path.
    typedef struct packed {
        logic signed [31:0] e0;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic [31:0]        lcg_old;
        logic [31:0]        lcg_new;
    } t_chan_state;

    localparam t_chan_state CHAN_RESET = '{
        e0: 32'sd0, e1: 32'sd0, e2: 32'sd0, lcg_old: 32'd0, lcg_new: LCG_INC
    };

    typedef struct packed {
        logic [31:0]       clip_cnt;
        logic [PEAK_W-1:0] peak_lvl;
        logic [31:0]       peak_ovs;
    } t_stats;

    typedef struct packed {
        logic [31:0] pcm_word;
        logic [2:0]  byte_count;
        logic        clipped;
        t_stats      stats;
        logic        blk_end;
    } t_result;

endpackage

>>> rtl/noise_shaped_pcm_dither_unit.sv
// Pipeline: an accepted item and its state memory read are registered in the
// state stage; the state stage does the whole per-item update, with a bypass
// for an item on the same channel directly behind, into the output register.
// Throughput: one item per cycle while i_ready does not hold off the output.
// Reset: synchronous, active low; channel state reads as its reset value, with
// zero errors, through per-entry valid bits (no clearing pass); statistics
// clear, the format becomes s16le.
// ----------------------------------------------------------------------------
// noise_shaped_pcm_dither_unit
// TPDF-dithered, noise-shaped requantizer with clip and peak statistics.
// ----------------------------------------------------------------------------
module noise_shaped_pcm_dither_unit
    import npd_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [31:0]   i_sample_value,
    input  logic                 i_channel,
    input  logic                 i_block_end,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_pcm_word,
    output logic [2:0]           o_byte_count,
    output logic                 o_clipped_now,
    output logic [31:0]          o_clip_count,
    output logic [PEAK_W-1:0]    o_peak_level,
    output logic [31:0]          o_peak_overshoot,
    output logic                 o_block_end_out
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ST_W = $bits(t_chan_state);

    logic [2:0]          r_fmt;
    logic                r_s1_valid, r_out_valid;
    logic signed [31:0]  r_s1_smp;
    logic [CH_W-1:0]     r_s1_ch;
    logic                r_s1_end;
    logic                r_byp, r_rd_vld;
    t_chan_state         r_byp_data;
    logic [CHANNELS-1:0] r_vld;
    t_stats              r_stats;
    t_result             r_out;

    logic                in_acc, s1_adv;
    logic [31:0]         ch_ext;
    logic [CH_W-1:0]     rd_addr;
    logic [ST_W-1:0]     ram_q;
    t_chan_state         cur_state, n_state;
    t_stats              n_stats;
    logic [31:0]         n_word;
    logic [2:0]          n_count;
    logic                n_clipped;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        ch_ext = 32'(i_channel);
        if (ch_ext >= 32'(CHANNELS)) begin
            ch_ext = 32'(CHANNELS - 1);
        end
        rd_addr = ch_ext[CH_W-1:0];
    end

    npd_ram #(
        .WIDTH (ST_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_ch),
        .i_wdata (n_state),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // A write landing on the entry being read is taken from the bypass copy.
    always_comb begin
        if (r_byp) begin
            cur_state = r_byp_data;
        end else if (r_rd_vld) begin
            cur_state = t_chan_state'(ram_q);
        end else begin
            cur_state = CHAN_RESET;
        end
    end

    npd_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .i_sample     (r_s1_smp),
        .i_fmt        (r_fmt),
        .i_state      (cur_state),
        .i_stats      (r_stats),
        .o_state      (n_state),
        .o_stats      (n_stats),
        .o_pcm_word   (n_word),
        .o_byte_count (n_count),
        .o_clipped    (n_clipped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_S16LE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_vld       <= '0;
            r_stats     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_data;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_byp      <= s1_adv && (r_s1_ch == rd_addr);
                r_rd_vld   <= r_vld[rd_addr];
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid      <= 1'b1;
                r_vld[r_s1_ch]   <= 1'b1;
                r_stats          <= n_stats;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_smp   <= i_sample_value;
            r_s1_ch    <= rd_addr;
            r_s1_end   <= i_block_end;
            r_byp_data <= n_state;
        end
        if (s1_adv) begin
            r_out.pcm_word   <= n_word;
            r_out.byte_count <= n_count;
            r_out.clipped    <= n_clipped;
            r_out.stats      <= n_stats;
            r_out.blk_end    <= r_s1_end;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pcm_word       = r_out.pcm_word;
    assign o_byte_count     = r_out.byte_count;
    assign o_clipped_now    = r_out.clipped;
    assign o_clip_count     = r_out.stats.clip_cnt;
    assign o_peak_level     = r_out.stats.peak_lvl;
    assign o_peak_overshoot = r_out.stats.peak_ovs;
    assign o_block_end_out  = r_out.blk_end;

    a_clip_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_stats.clip_cnt >= $past(r_stats.clip_cnt))
        else $error("clip count decreased");

    a_ovs_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_stats.peak_ovs >= $past(r_stats.peak_ovs))
        else $error("peak overshoot decreased");

    a_clip_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.clipped |-> r_out.stats.clip_cnt != 32'd0)
        else $error("clipped item with zero clip count");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_ch) && $stable(r_byp))
        else $error("stalled item in state stage changed");

endmodule

>>> rtl/npd_ram.sv
// ----------------------------------------------------------------------------
// npd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module npd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/npd_calc.sv
// ----------------------------------------------------------------------------
// npd_calc
// Byte packing of one quantized sample for the selected output format.
// ----------------------------------------------------------------------------
module npd_calc
    import npd_pkg::*;
(
    input  logic [2:0]  i_fmt,
    input  logic [23:0] i_value,
    output logic [31:0] o_pcm_word,
    output logic [2:0]  o_byte_count
);

    always_comb begin
        case (i_fmt)
            FMT_S8: begin
                o_pcm_word   = {24'd0, i_value[7:0]};
                o_byte_count = 3'd1;
            end
            FMT_U8: begin
                o_pcm_word   = {24'd0, i_value[7:0] ^ SIGN_FLIP};
                o_byte_count = 3'd1;
            end
            FMT_S16LE: begin
                o_pcm_word   = {16'd0, i_value[15:0]};
                o_byte_count = 3'd2;
            end
            FMT_S16BE: begin
                o_pcm_word   = {16'd0, i_value[7:0], i_value[15:8]};
                o_byte_count = 3'd2;
            end
            FMT_S24LE: begin
                o_pcm_word   = {8'd0, i_value};
                o_byte_count = 3'd3;
            end
            FMT_S24BE: begin
                o_pcm_word   = {8'd0, i_value[7:0], i_value[15:8], i_value[23:16]};
                o_byte_count = 3'd3;
            end
            FMT_S32LE: begin
                o_pcm_word   = {i_value, 8'd0};
                o_byte_count = 3'd4;
            end
            default: begin
                o_pcm_word   = {8'd0, i_value[7:0], i_value[15:8], i_value[23:16]};
                o_byte_count = 3'd4;
            end
        endcase
    end

endmodule

>>> rtl/npd_core.sv
// ----------------------------------------------------------------------------
// npd_core
// Noise shaping, dither, clipping, quantization and byte packing of one item.
// ----------------------------------------------------------------------------
module npd_core
    import npd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic signed [31:0] i_sample,
    input  logic [2:0]         i_fmt,
    input  t_chan_state        i_state,
    input  t_stats             i_stats,
    output t_chan_state        o_state,
    output t_stats             o_stats,
    output logic [31:0]        o_pcm_word,
    output logic [2:0]         o_byte_count,
    output logic               o_clipped
);

    localparam int ACC_W = 36;
    localparam int SC8   = FRAC_BITS - 7;
    localparam int SC16  = FRAC_BITS - 15;
    localparam int SC24  = FRAC_BITS - 23;

    localparam logic signed [ACC_W-1:0] FS_ONE = ACC_W'(1) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] FS_MAX = FS_ONE - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] FS_MIN = -FS_ONE;
    localparam logic signed [ACC_W-1:0] PEAK_SAT_A = ACC_W'(PEAK_SAT);
    localparam logic signed [ACC_W-1:0] U32_MAX_A  = ACC_W'(SAT_U32);
    localparam logic signed [ACC_W-1:0] S32_MAX_A  = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] S32_MIN_A  = -(S32_MAX_A + ACC_W'(1));

    localparam logic [31:0] MASK8  = (32'd1 << SC8) - 32'd1;
    localparam logic [31:0] MASK16 = (32'd1 << SC16) - 32'd1;
    localparam logic [31:0] MASK24 = (32'd1 << SC24) - 32'd1;

    logic                    is8, is16;
    logic [31:0]             mask;
    logic signed [ACC_W-1:0] mask_a, bias, smp_sh, dith, acc0, pk;
    logic signed [ACC_W-1:0] acc, smp, excess, level, q, err;
    logic                    clipped, upd_peak;
    logic [31:0]             ex32, lcg_mul;
    logic [23:0]             u;

    assign is8  = (i_fmt == FMT_S8) || (i_fmt == FMT_U8);
    assign is16 = (i_fmt == FMT_S16LE) || (i_fmt == FMT_S16BE);

    always_comb begin
        if (is8) begin
            mask = MASK8;
        end else if (is16) begin
            mask = MASK16;
        end else begin
            mask = MASK24;
        end
        mask_a = $signed(ACC_W'(mask));
        // Half an output step: the mask shifted down by one, plus one.
        bias   = $signed(ACC_W'(mask >> 1)) + ACC_W'(1);
        smp_sh = ACC_W'(i_sample) + ACC_W'(i_state.e0) - ACC_W'(i_state.e1)
               + ACC_W'(i_state.e2);
        dith   = $signed(ACC_W'(i_state.lcg_new & mask))
               - $signed(ACC_W'(i_state.lcg_old & mask));
        acc0   = smp_sh + bias + dith;
        pk     = $signed(ACC_W'(i_stats.peak_lvl));
    end

    always_comb begin
        acc      = acc0;
        smp      = smp_sh;
        clipped  = 1'b0;
        upd_peak = 1'b0;
        excess   = '0;
        level    = '0;
        if (acc0 >= pk) begin
            upd_peak = 1'b1;
            if (acc0 > FS_MAX) begin
                clipped = 1'b1;
                excess  = acc0 - FS_MAX;
                acc     = FS_MAX;
                if (smp_sh > FS_MAX) begin
                    smp = FS_MAX;
                end
            end
            level = acc;
        end else if (acc0 < -pk) begin
            upd_peak = 1'b1;
            if (acc0 < FS_MIN) begin
                clipped = 1'b1;
                excess  = FS_MIN - acc0;
                acc     = FS_MIN;
                if (smp_sh < FS_MIN) begin
                    smp = FS_MIN;
                end
            end
            level = -acc;
        end
    end

    assign ex32 = (excess > U32_MAX_A) ? SAT_U32 : excess[31:0];

    always_comb begin
        o_stats = i_stats;
        if (upd_peak) begin
            o_stats.peak_lvl = (level > PEAK_SAT_A) ? PEAK_SAT : level[PEAK_W-1:0];
        end
        if (clipped) begin
            if (i_stats.clip_cnt != SAT_U32) begin
                o_stats.clip_cnt = i_stats.clip_cnt + 32'd1;
            end
            if (ex32 > i_stats.peak_ovs) begin
                o_stats.peak_ovs = ex32;
            end
        end
    end

    // Quantize by clearing the bits below the output step.
    assign q   = acc & ~mask_a;
    assign err = smp - q;

    always_comb begin
        if (is8) begin
            u = 24'(q >>> SC8);
        end else if (is16) begin
            u = 24'(q >>> SC16);
        end else begin
            u = 24'(q >>> SC24);
        end
    end

    assign lcg_mul = i_state.lcg_new * LCG_MUL;

    always_comb begin
        o_state.e2      = i_state.e1;
        o_state.e1      = i_state.e0 / 32'sd2;
        if (err > S32_MAX_A) begin
            o_state.e0 = 32'sh7FFF_FFFF;
        end else if (err < S32_MIN_A) begin
            o_state.e0 = 32'sh8000_0000;
        end else begin
            o_state.e0 = err[31:0];
        end
        o_state.lcg_old = i_state.lcg_new;
        o_state.lcg_new = lcg_mul + LCG_INC;
    end

    npd_calc u_pack (
        .i_fmt        (i_fmt),
        .i_value      (u),
        .o_pcm_word   (o_pcm_word),
        .o_byte_count (o_byte_count)
    );

    assign o_clipped = clipped;

endmodule

>>> dv/noise_shaped_pcm_dither_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_shaped_pcm_dither_unit_tb
// Drives audio samples on both channels through every output format, keeps a
// cycle-free model of the dither, noise shaping, clipping and statistics, and
// compares every result item field by field against it.
// ----------------------------------------------------------------------------
module noise_shaped_pcm_dither_unit_tb
    import npd_pkg::*;
();

    localparam int     QUIET_LIMIT  = 2000;
    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 183;
    localparam int     HOLD_CYCLES  = 80;
    localparam longint FS_MAX       = (longint'(1) << FRAC_BITS_DEF) - 1;
    localparam longint FS_MIN       = -(longint'(1) << FRAC_BITS_DEF);
    localparam longint I32_MAX      = (longint'(1) << 31) - 1;
    localparam longint I32_MIN      = -(longint'(1) << 31);

    typedef struct packed {
        logic [31:0]       pcm_word;
        logic [2:0]        byte_count;
        logic              clipped_now;
        logic [31:0]       clip_count;
        logic [PEAK_W-1:0] peak_level;
        logic [31:0]       peak_overshoot;
        logic              block_end_out;
    } pcm_result_t;

    typedef struct packed {
        logic [2:0]  fmt;
        int          sample;
        bit          ch;
        bit          be;
        bit          fixed;
        pcm_result_t want;
    } stim_row_t;

    // First sample after reset: zero input, s16le, channel 0. The rounding bias
    // plus the first dither step lands just above one LSB.
    localparam pcm_result_t AFTER_RESET = '{
        32'h0000_0001, 3'd2, 1'b0, 32'd0, 28'h000_235F, 32'd0, 1'b0
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_data = 3'd0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic signed [31:0] i_sample_value = '0;
    logic              i_channel = 1'b0;
    logic              i_block_end = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [31:0]       o_pcm_word;
    logic [2:0]        o_byte_count;
    logic              o_clipped_now;
    logic [31:0]       o_clip_count;
    logic [PEAK_W-1:0] o_peak_level;
    logic [31:0]       o_peak_overshoot;
    logic              o_block_end_out;

    // Model state, mirrored from the block.
    int                err_now [2] = '{0, 0};
    int                err_d1 [2] = '{0, 0};
    int                err_d2 [2] = '{0, 0};
    logic [31:0]       dither_seed [2] = '{32'd0, 32'd0};
    logic [PEAK_W-1:0] peak_hold = '0;
    logic [31:0]       clips_seen = '0;
    logic [31:0]       worst_overshoot = '0;
    logic [2:0]        format_sel = FMT_S16LE;

    pcm_result_t       pcm_due [$];
    pcm_result_t       got_want;
    stim_row_t         dir_rows [22];
    int                mismatches = 0;
    int                quiet = 0;
    bit                tx_idle_on = 1'b1;
    bit                rx_idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int                hold_left = 0;
    int                stall_left = 0;

    noise_shaped_pcm_dither_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_value   (i_sample_value),
        .i_channel        (i_channel),
        .i_block_end      (i_block_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_pcm_word       (o_pcm_word),
        .o_byte_count     (o_byte_count),
        .o_clipped_now    (o_clipped_now),
        .o_clip_count     (o_clip_count),
        .o_peak_level     (o_peak_level),
        .o_peak_overshoot (o_peak_overshoot),
        .o_block_end_out  (o_block_end_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Dithers, shapes, clips and quantizes one sample, updating the model state.
    function automatic pcm_result_t requantize(input int sample, input bit ch, input bit be);
        longint      smp, acc, mask, q, v, level, excess, diff, d_new, d_old;
        int          shift;
        logic [31:0] seed_old, seed_new, u, ovs;
        pcm_result_t r;
        r = '0;
        shift = FRAC_BITS_DEF + 1 - ((format_sel < FMT_S16LE) ? 8 :
                                     (format_sel < FMT_S24LE) ? 16 : 24);
        mask = (longint'(1) << shift) - 1;

        smp = longint'(sample) + longint'(err_now[ch]) - longint'(err_d1[ch])
            + longint'(err_d2[ch]);
        err_d2[ch] = err_d1[ch];
        err_d1[ch] = err_now[ch] / 2;

        acc = smp + (longint'(1) << (shift - 1));
        seed_old = dither_seed[ch];
        seed_new = seed_old * LCG_MUL + LCG_INC;
        d_new = seed_new & mask[31:0];
        d_old = seed_old & mask[31:0];
        acc = acc + d_new - d_old;
        dither_seed[ch] = seed_new;

        level = peak_hold;
        excess = 0;
        if (acc >= level) begin
            if (acc > FS_MAX) begin
                r.clipped_now = 1'b1;
                excess = acc - FS_MAX;
                acc = FS_MAX;
                if (smp > FS_MAX) smp = FS_MAX;
            end
            peak_hold = (acc > longint'(PEAK_SAT)) ? PEAK_SAT : acc[PEAK_W-1:0];
        end else if (acc < -level) begin
            if (acc < FS_MIN) begin
                r.clipped_now = 1'b1;
                excess = FS_MIN - acc;
                acc = FS_MIN;
                if (smp < FS_MIN) smp = FS_MIN;
            end
            // A level of exactly full scale does not fit and saturates.
            peak_hold = (-acc > longint'(PEAK_SAT)) ? PEAK_SAT : PEAK_W'(-acc);
        end
        if (r.clipped_now) begin
            ovs = (excess > longint'(SAT_U32)) ? SAT_U32 : excess[31:0];
            if (clips_seen != SAT_U32) clips_seen = clips_seen + 1;
            if (ovs > worst_overshoot) worst_overshoot = ovs;
        end

        q = acc - (acc & mask);
        diff = smp - q;
        err_now[ch] = (diff > I32_MAX) ? 32'h7FFF_FFFF :
                      (diff < I32_MIN) ? 32'h8000_0000 : int'(diff);
        v = q >>> shift;
        u = v[31:0];

        case (format_sel)
            FMT_S8: begin
                r.pcm_word = {24'd0, u[7:0]};
                r.byte_count = 3'd1;
            end
            FMT_U8: begin
                r.pcm_word = {24'd0, u[7:0] ^ SIGN_FLIP};
                r.byte_count = 3'd1;
            end
            FMT_S16LE: begin
                r.pcm_word = {16'd0, u[15:0]};
                r.byte_count = 3'd2;
            end
            FMT_S16BE: begin
                r.pcm_word = {16'd0, u[7:0], u[15:8]};
                r.byte_count = 3'd2;
            end
            FMT_S24LE: begin
                r.pcm_word = {8'd0, u[23:0]};
                r.byte_count = 3'd3;
            end
            FMT_S24BE: begin
                r.pcm_word = {8'd0, u[7:0], u[15:8], u[23:16]};
                r.byte_count = 3'd3;
            end
            FMT_S32LE: begin
                r.pcm_word = {u[23:0], 8'd0};
                r.byte_count = 3'd4;
            end
            default: begin
                r.pcm_word = {8'd0, u[7:0], u[15:8], u[23:16]};
                r.byte_count = 3'd4;
            end
        endcase

        r.clip_count = clips_seen;
        r.peak_level = peak_hold;
        r.peak_overshoot = worst_overshoot;
        r.block_end_out = be;
        return r;
    endfunction

    // Mostly in-range audio, some quiet passages, some near full scale on either
    // side of it, and a few arbitrary words.
    function automatic int pick_sample();
        int k, mag;
        k = $urandom_range(0, 19);
        if (k < 12) return int'($urandom_range(0, 32'h1FFF_FFFF)) - (1 << 28);
        if (k < 15) return int'($urandom_range(0, 131071)) - 65536;
        if (k < 18) begin
            mag = (1 << 28) + int'($urandom_range(0, 65535)) - 32768;
            return $urandom_range(0, 1) ? mag : -mag;
        end
        return int'($urandom);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic offer(input int sample, input bit ch, input bit be,
                         input bit fixed, input pcm_result_t want);
        pcm_result_t r;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_sample_value = sample;
        i_channel = ch;
        i_block_end = be;
        do @(posedge i_clk); while (!o_ready);
        r = requantize(sample, ch, be);
        pcm_due.push_back(fixed ? want : r);
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge i_clk);
        i_valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // The format only changes once the pipeline has emptied.
    task automatic switch_format(input logic [2:0] fmt);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pcm_due.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = fmt;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        format_sel = fmt;
    endtask

    initial begin : stimulus
        logic [2:0] fmt;
        dir_rows = '{
            '{FMT_S16LE,  32'sh0000_0000, 1'b0, 1'b0, 1'b1, AFTER_RESET},
            '{FMT_S16LE,  32'sh0010_0000, 1'b0, 1'b1, 1'b0, '0},
            '{FMT_S16LE, -32'sh0020_0000, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S16LE,  32'sh0100_0000, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S16LE, -32'sh0400_0000, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_S8,     32'sh0030_0000, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_U8,    -32'sh0030_0000, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_U8,     32'sh0800_0000, 1'b0, 1'b1, 1'b0, '0},
            '{FMT_S16BE,  32'sh0012_3456, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_S24LE, -32'sh00AB_CDEF, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S24BE,  32'sh0ABC_DEF0, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_S32LE, -32'sh0123_4567, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S32BE,  32'sh0765_4321, 1'b0, 1'b0, 1'b0, '0},
            // Past negative full scale: the peak saturates from below.
            '{FMT_S32BE, -32'sh1010_0000, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S32BE,  32'sh0FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_S32BE, -32'sh1000_0000, 1'b1, 1'b1, 1'b0, '0},
            '{FMT_S32LE,  32'sh7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_S32LE,  32'sh8000_0000, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_S8,     32'sh7FFF_FFFF, 1'b1, 1'b0, 1'b0, '0},
            '{FMT_U8,     32'sh8000_0000, 1'b0, 1'b0, 1'b0, '0},
            '{FMT_U8,     32'sh7FFF_FFFF, 1'b0, 1'b1, 1'b0, '0},
            '{FMT_S16LE,  32'shFFFF_FFFF, 1'b1, 1'b1, 1'b0, '0}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].fmt != format_sel) switch_format(dir_rows[n].fmt);
            offer(dir_rows[n].sample, dir_rows[n].ch, dir_rows[n].be,
                  dir_rows[n].fixed, dir_rows[n].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            fmt = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
            switch_format(fmt);
            // Phase 4 runs without idling; the last phase does too.
            tx_idle_on = (p != 4 && p != PHASES - 1);
            rx_idle_on = tx_idle_on;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == 40) hold_req = 1'b1;
                if (p == 6 && n == 90) begin
                    sender_gap(1);
                    while (pcm_due.size() != 0) @(posedge i_clk);
                end
                if (tx_idle_on && $urandom_range(0, 7) == 0)
                    sender_gap($urandom_range(1, 9));
                offer(pick_sample(), 1'($urandom_range(0, 1)),
                      ($urandom_range(0, 15) == 0), 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pcm_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Output side: random stalls, plus one long hold-off that backs up the
    // pipeline while the sender keeps offering items.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            i_ready = 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            i_ready = 1'b0;
            stall_left = $urandom_range(0, 8);
        end else begin
            i_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pcm_due.size() == 0) begin
                $error("result item arrived with none pending");
                mismatches++;
            end else begin
                got_want = pcm_due.pop_front();
                check_field("pcm_word", got_want.pcm_word, o_pcm_word);
                check_field("byte_count", 32'(got_want.byte_count), 32'(o_byte_count));
                check_field("clipped_now", 32'(got_want.clipped_now),
                            32'(o_clipped_now));
                check_field("clip_count", got_want.clip_count, o_clip_count);
                check_field("peak_level", 32'(got_want.peak_level), 32'(o_peak_level));
                check_field("peak_overshoot", got_want.peak_overshoot, o_peak_overshoot);
                check_field("block_end_out", 32'(got_want.block_end_out),
                            32'(o_block_end_out));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
